@@ rtl/core/uaf_pkg.sv @@
package uaf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_CHARS   = 3;

  localparam logic [6:0] CH_A = 7'h61;
  localparam logic [6:0] CH_C = 7'h63;
  localparam logic [6:0] CH_D = 7'h64;
  localparam logic [6:0] CH_E = 7'h65;
  localparam logic [6:0] CH_H = 7'h68;
  localparam logic [6:0] CH_I = 7'h69;
  localparam logic [6:0] CH_N = 7'h6E;
  localparam logic [6:0] CH_O = 7'h6F;
  localparam logic [6:0] CH_S = 7'h73;
  localparam logic [6:0] CH_T = 7'h74;
  localparam logic [6:0] CH_U = 7'h75;
  localparam logic [6:0] CH_Y = 7'h79;

  localparam logic [6:0] UPPER_FIRST = 7'h41;
  localparam logic [6:0] UPPER_LAST  = 7'h5A;
  localparam logic [6:0] CASE_OFFSET = 7'h20;
  // Upper bits shared by the two ligature code points 0x152 and 0x153.
  localparam logic [19:0] OE_PAIR    = 20'h000A9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
  } out_beat_t;

  // Characters produced by one code point: zero, one or two.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0][6:0] ch;
  } fold_t;

  // Characters produced by one input beat, first character in ch[0].
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_CHARS-1:0][6:0] ch;
  } run_t;

  function automatic fold_t fold_one(input logic [6:0] c);
    fold_t r;
    r.cnt   = 2'd1;
    r.ch[0] = c;
    r.ch[1] = '0;
    return r;
  endfunction

  function automatic fold_t fold_two(input logic [6:0] c0, input logic [6:0] c1);
    fold_t r;
    r.cnt   = 2'd2;
    r.ch[0] = c0;
    r.ch[1] = c1;
    return r;
  endfunction

  // Lowercase accent fold of one code point.
  function automatic fold_t fold_cp(input logic [20:0] cp);
    fold_t r;
    r = '0;
    if (cp[20:7] == '0) begin
      r = fold_one((cp[6:0] inside {[UPPER_FIRST:UPPER_LAST]}) ?
                   cp[6:0] + CASE_OFFSET : cp[6:0]);
    end else if (cp[20:8] == '0 && cp[7:6] == 2'b11) begin
      // Upper and lower case halves of Latin-1 fold alike, except at the very end.
      case (cp[4:0]) inside
        [5'd0:5'd5]:   r = fold_one(CH_A);
        5'd6:          r = fold_two(CH_A, CH_E);
        5'd7:          r = fold_one(CH_C);
        [5'd8:5'd11]:  r = fold_one(CH_E);
        [5'd12:5'd15]: r = fold_one(CH_I);
        5'd16:         r = fold_one(CH_D);
        5'd17:         r = fold_one(CH_N);
        [5'd18:5'd22]: r = fold_one(CH_O);
        5'd24:         r = fold_one(CH_O);
        [5'd25:5'd28]: r = fold_one(CH_U);
        5'd29:         r = fold_one(CH_Y);
        5'd30:         r = fold_two(CH_T, CH_H);
        5'd31:         r = cp[5] ? fold_one(CH_Y) : fold_two(CH_S, CH_S);
        default:       r = '0;
      endcase
    end else if (cp[20:1] == OE_PAIR) begin
      r = fold_two(CH_O, CH_E);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/utf8_accent_fold.sv @@
// UTF-8 to lowercase accent-folded ASCII converter.
// Input channel (in_valid/in_ready/in_data): one text byte per beat, with an
// end_of_text flag that flushes any partially gathered code point.
// Output channel (out_valid/out_ready/out_data): zero to three folded ASCII
// characters per input beat, last_of_run marking the final one of each byte.
// A front stage decodes each byte in the cycle it is accepted and writes the
// characters it causes as one run into a small queue; a back stage plays runs
// out one character per cycle while out_ready is high.
// Throughput: one input byte per cycle while bytes produce at most one
// character each and the receiver takes every character; a byte producing
// several characters holds the output until all are taken. A character is
// offered after its run is written to the queue and loaded by the back stage.
// When the receiver stalls, the queue absorbs up to QUEUE_DEPTH runs behind the
// one held by the back stage; once it is full in_ready drops for every byte,
// including bytes that would produce no character.
// Reset (rst_n low, synchronous) empties the queue and closes any open
// sequence; no output beat is offered until new input arrives.
module utf8_accent_fold #(
  parameter int QUEUE_DEPTH = uaf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uaf_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output uaf_pkg::out_beat_t out_data
);

  logic          in_accept;
  logic          q_push;
  uaf_pkg::run_t q_push_run;
  logic          q_pop;
  logic          q_head_valid;
  uaf_pkg::run_t q_head_run;
  logic          q_full;

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  uaf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_data  (in_data),
    .push     (q_push),
    .push_run (q_push_run)
  );

  uaf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_run  (q_push_run),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_run  (q_head_run),
    .full      (q_full)
  );

  uaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_run  (q_head_run),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("run written into a full queue");

  a_no_empty_runs : assert property (@(posedge clk) disable iff (!rst_n)
    q_head_valid |-> q_head_run.cnt != 2'd0)
    else $error("queue holds a run with no characters");

  a_ascii_reaches_output : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_data.in_byte[7]) |=> (out_valid || q_head_valid))
    else $error("ASCII byte produced no pending character");

  a_pop_only_with_data : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

endmodule

@@ rtl/core/uaf_front.sv @@
module uaf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  uaf_pkg::in_beat_t  in_data,
  output logic               push,
  output uaf_pkg::run_t      push_run
);

  localparam logic [1:0] CONT_PFX  = 2'b10;
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;

  logic [20:0]   pending_r, pending_nxt;
  logic [1:0]    left_r, left_nxt;
  logic          taken;
  logic [7:0]    b;
  uaf_pkg::fold_t folds [3];
  logic [1:0]    fill;
  uaf_pkg::run_t run;

  assign b = in_data.in_byte;

  always_comb begin
    pending_nxt = pending_r;
    left_nxt    = left_r;
    taken       = 1'b0;
    folds[0]    = '0;
    folds[1]    = '0;
    folds[2]    = '0;

    if (left_r != 2'd0) begin
      if (b[7:6] == CONT_PFX) begin
        pending_nxt = {pending_r[14:0], b[5:0]};
        left_nxt    = left_r - 2'd1;
        if (left_nxt == 2'd0) begin
          folds[1]    = uaf_pkg::fold_cp(pending_nxt);
          pending_nxt = '0;
        end
        taken = 1'b1;
      end else begin
        // Broken sequence: emit what was gathered, then treat the byte afresh.
        folds[0]    = uaf_pkg::fold_cp(pending_r);
        pending_nxt = '0;
        left_nxt    = 2'd0;
      end
    end

    if (!taken) begin
      if (!b[7]) begin
        folds[1] = uaf_pkg::fold_cp({13'd0, b});
      end else if (b[7:5] == LEAD2_PFX) begin
        pending_nxt = {16'd0, b[4:0]};
        left_nxt    = 2'd1;
      end else if (b[7:4] == LEAD3_PFX) begin
        pending_nxt = {17'd0, b[3:0]};
        left_nxt    = 2'd2;
      end else if (b[7:3] == LEAD4_PFX) begin
        pending_nxt = {18'd0, b[2:0]};
        left_nxt    = 2'd3;
      end
    end

    if (in_data.end_of_text && left_nxt != 2'd0) begin
      folds[2]    = uaf_pkg::fold_cp(pending_nxt);
      pending_nxt = '0;
      left_nxt    = 2'd0;
    end

    // Pack the up to six candidate characters into at most three slots.
    fill   = 2'd0;
    run.ch = '0;
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < folds[s].cnt && fill != 2'd3) begin
          run.ch[fill] = folds[s].ch[k];
          fill         = fill + 2'd1;
        end
      end
    end
    run.cnt = fill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      left_r    <= 2'd0;
    end else if (in_accept) begin
      pending_r <= pending_nxt;
      left_r    <= left_nxt;
    end
  end

  assign push     = in_accept && (run.cnt != 2'd0);
  assign push_run = run;

endmodule

@@ rtl/core/uaf_queue.sv @@
module uaf_queue #(
  parameter int DEPTH = uaf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uaf_pkg::run_t push_run,
  input  logic          pop,
  output logic          head_valid,
  output uaf_pkg::run_t head_run,
  output logic          full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uaf_pkg::run_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_run;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_run   = entries[rd_ptr_r];
  assign full       = (count_r == CNT_W'(DEPTH));

endmodule

@@ rtl/core/uaf_back.sv @@
module uaf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  uaf_pkg::run_t      head_run,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output uaf_pkg::out_beat_t out_data
);

  uaf_pkg::run_t run_r, run_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic          busy_r, busy_nxt;
  logic          last;
  logic          finishing;

  assign last      = (sel_r == run_r.cnt - 2'd1);
  assign finishing = busy_r && out_ready && last;
  // A new run loads in the same cycle the previous one hands over its last beat.
  assign pop       = head_valid && (!busy_r || finishing);

  always_comb begin
    run_nxt  = run_r;
    sel_nxt  = sel_r;
    busy_nxt = busy_r;
    if (pop) begin
      run_nxt  = head_run;
      sel_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (finishing) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      sel_nxt = sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  assign out_valid            = busy_r;
  assign out_data.out_char    = (sel_r == 2'd3) ? '0 : run_r.ch[sel_r];
  assign out_data.last_of_run = last;

endmodule
